// ===== sv/rgbm_pkg.sv =====
// rgbm_pkg: shared types, constants and luma tables for the rgb565 mono packer
// no dependencies; imported by every module of the block

package rgbm_pkg;

    // rgb565 channel layout
    localparam int R_MAX = 31;
    localparam int G_MAX = 63;
    localparam int C8_MAX = 255;

    // luma weights and black/white threshold
    localparam int LUMA_WEIGHT_R = 299;
    localparam int LUMA_WEIGHT_G = 587;
    localparam int LUMA_WEIGHT_B = 114;
    localparam int LUMA_W = 18;
    localparam logic [LUMA_W-1:0] LUMA_THRESHOLD = 18'd128000;

    // result field widths
    localparam int BYTE_COL_W = 7;
    localparam int OUT_ROW_W = 10;

    // queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

    // all-white refill value of the packing byte
    localparam logic [7:0] ACC_ALL_WHITE = 8'hFF;
    localparam logic [7:0] BIT_MSB = 8'h80;

    // configuration register indexes
    typedef enum logic [1:0] {
        REG_X_FIRST = 2'd0,
        REG_X_LAST  = 2'd1,
        REG_Y_FIRST = 2'd2,
        REG_Y_LAST  = 2'd3
    } reg_idx_t;

    // weighted luma contribution tables, per channel code
    typedef logic [31:0][LUMA_W-1:0] tab5_t;
    typedef logic [63:0][LUMA_W-1:0] tab6_t;

    function automatic tab5_t build_tab5(input int weight);
        tab5_t t;
        for (int i = 0; i < 32; i++) begin
            t[i] = LUMA_W'((i * C8_MAX / R_MAX) * weight);
        end
        return t;
    endfunction

    function automatic tab6_t build_tab6(input int weight);
        tab6_t t;
        for (int i = 0; i < 64; i++) begin
            t[i] = LUMA_W'((i * C8_MAX / G_MAX) * weight);
        end
        return t;
    endfunction

    localparam tab5_t R_LUMA_TAB = build_tab5(LUMA_WEIGHT_R);
    localparam tab6_t G_LUMA_TAB = build_tab6(LUMA_WEIGHT_G);
    localparam tab5_t B_LUMA_TAB = build_tab5(LUMA_WEIGHT_B);

    // one classified pixel travelling from front to back
    typedef struct packed {
        logic                  white;
        logic [2:0]            bit_pos;
        logic                  emit;
        logic                  last_col;
        logic [BYTE_COL_W-1:0] byte_col;
        logic [OUT_ROW_W-1:0]  row;
    } q_entry_t;

endpackage

// ===== sv/rgb565_to_mono_packer_unit.sv =====
// rgb565_to_mono_packer_unit: top level with configuration registers
// depends on rgbm_pkg, rgbm_front, rgbm_queue and rgbm_back

// Accepts one RGB565 pixel per clock with its column and row, drops pixels
// outside the capture window, thresholds the weighted luma to black or white
// and packs eight pixels per byte, MSB leftmost. A byte leaves at column bit 7
// or at the window's last column; tlast marks the latter. Sustained rate is
// one pixel per cycle: classification is a single combinational stage into a
// four-entry queue, and the packer drains one queued pixel per cycle into a
// single output register; a pixel is registered first in the queue. s_tready
// falls only when the queue is full, which happens when the output side
// stalls. Window registers sit at byte addresses 0, 4, 8 and 12 (x first,
// x last, y first, y last); the user must write them while the stream is idle,
// not enforced by the block; reset window is columns 0..799, rows 0..479.

module rgb565_to_mono_packer_unit #(
    parameter int COORD_BITS = 10
) (
    input  logic        aclk,
    input  logic        aresetn,
    // input pixels
    input  logic        s_tvalid,
    output logic        s_tready,
    // tdata: pixel_rgb565[15:0], column, row, zero fill to whole bytes
    input  logic [((16+2*COORD_BITS+7)/8)*8-1:0] s_tdata,
    // packed bytes
    output logic        m_tvalid,
    input  logic        m_tready,
    // tdata: packed_byte[7:0], byte_column[14:8], out_row[24:15], zero fill
    output logic [31:0] m_tdata,
    // tlast: row_end
    output logic        m_tlast,
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import rgbm_pkg::*;

    localparam logic [COORD_BITS-1:0] X_LAST_RST = COORD_BITS'(799);
    localparam logic [COORD_BITS-1:0] Y_LAST_RST = COORD_BITS'(479);

    logic [COORD_BITS-1:0] x_first_reg, x_last_reg, y_first_reg, y_last_reg;
    logic                  cfg_wr;
    reg_idx_t              cfg_idx;

    logic [15:0]           pix;
    logic [COORD_BITS-1:0] col;
    logic [COORD_BITS-1:0] row;

    logic                  push;
    q_entry_t              push_entry;
    logic                  q_not_full;
    logic                  q_pop;
    logic                  q_not_empty;
    q_entry_t              pop_entry;

    logic [7:0]            packed_byte;
    logic [BYTE_COL_W-1:0] byte_column;
    logic [OUT_ROW_W-1:0]  out_row;

    // register access
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = reg_idx_t'(paddr[3:2]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            x_first_reg <= '0;
            x_last_reg  <= X_LAST_RST;
            y_first_reg <= '0;
            y_last_reg  <= Y_LAST_RST;
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_X_FIRST: x_first_reg <= pwdata[COORD_BITS-1:0];
                REG_X_LAST:  x_last_reg  <= pwdata[COORD_BITS-1:0];
                REG_Y_FIRST: y_first_reg <= pwdata[COORD_BITS-1:0];
                REG_Y_LAST:  y_last_reg  <= pwdata[COORD_BITS-1:0];
                default: ;
            endcase
        end
    end

    // register readback
    always_comb begin
        case (cfg_idx)
            REG_X_FIRST: prdata = 32'(x_first_reg);
            REG_X_LAST:  prdata = 32'(x_last_reg);
            REG_Y_FIRST: prdata = 32'(y_first_reg);
            REG_Y_LAST:  prdata = 32'(y_last_reg);
            default:     prdata = '0;
        endcase
    end

    // input field unpacking
    assign pix = s_tdata[15:0];
    assign col = s_tdata[16 +: COORD_BITS];
    assign row = s_tdata[16+COORD_BITS +: COORD_BITS];

    assign s_tready = q_not_full;

    rgbm_front #(
        .COORD_BITS(COORD_BITS)
    ) u_front (
        .in_valid      (s_tvalid),
        .in_ready      (q_not_full),
        .pixel_rgb565  (pix),
        .column        (col),
        .row           (row),
        .window_x_first(x_first_reg),
        .window_x_last (x_last_reg),
        .window_y_first(y_first_reg),
        .window_y_last (y_last_reg),
        .push          (push),
        .entry         (push_entry)
    );

    rgbm_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_entry(push_entry),
        .not_full  (q_not_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .pop_entry (pop_entry)
    );

    rgbm_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .q_not_empty(q_not_empty),
        .q_entry    (pop_entry),
        .q_pop      (q_pop),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .packed_byte(packed_byte),
        .byte_column(byte_column),
        .out_row    (out_row),
        .row_end    (m_tlast)
    );

    // result packing
    assign m_tdata = {7'd0, out_row, byte_column, packed_byte};

endmodule

// ===== sv/rgbm_front.sv =====
// rgbm_front: window check and black/white classification of incoming pixels
// depends on rgbm_pkg for the luma tables and the queue entry type

module rgbm_front #(
    parameter int COORD_BITS = 10
) (
    input  logic                    in_valid,
    input  logic                    in_ready,
    input  logic [15:0]             pixel_rgb565,
    input  logic [COORD_BITS-1:0]   column,
    input  logic [COORD_BITS-1:0]   row,
    input  logic [COORD_BITS-1:0]   window_x_first,
    input  logic [COORD_BITS-1:0]   window_x_last,
    input  logic [COORD_BITS-1:0]   window_y_first,
    input  logic [COORD_BITS-1:0]   window_y_last,
    output logic                    push,
    output rgbm_pkg::q_entry_t      entry
);
    import rgbm_pkg::*;

    logic                    in_win;
    logic [LUMA_W-1:0]       luma;
    logic [COORD_BITS+6:0]   col_wide;
    logic [COORD_BITS+6:0]   col_shift;
    logic [COORD_BITS+9:0]   row_wide;
    logic                    last_col;

    // capture window test
    assign in_win = (column >= window_x_first) && (column <= window_x_last) &&
                    (row >= window_y_first) && (row <= window_y_last);

    // weighted luma from per-channel tables
    assign luma = R_LUMA_TAB[pixel_rgb565[15:11]] +
                  G_LUMA_TAB[pixel_rgb565[10:5]] +
                  B_LUMA_TAB[pixel_rgb565[4:0]];

    // byte index and row at result widths
    assign col_wide  = (COORD_BITS+7)'(column);
    assign col_shift = col_wide >> 3;
    assign row_wide  = (COORD_BITS+10)'(row);
    assign last_col  = (column == window_x_last);

    // only kept pixels enter the queue
    assign push = in_valid && in_ready && in_win;

    always_comb begin
        entry.white    = (luma >= LUMA_THRESHOLD);
        entry.bit_pos  = column[2:0];
        entry.last_col = last_col;
        entry.emit     = (column[2:0] == 3'd7) || last_col;
        entry.byte_col = col_shift[BYTE_COL_W-1:0];
        entry.row      = row_wide[OUT_ROW_W-1:0];
    end

endmodule

// ===== sv/rgbm_queue.sv =====
// rgbm_queue: short first-in first-out queue of classified pixels
// depends on rgbm_pkg for the entry type and depth

module rgbm_queue (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  rgbm_pkg::q_entry_t  push_entry,
    output logic                not_full,
    input  logic                pop,
    output logic                not_empty,
    output rgbm_pkg::q_entry_t  pop_entry
);
    import rgbm_pkg::*;

    q_entry_t               slots [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_PTR_W:0]   count_reg, count_next;

    assign not_full  = (count_reg != (QUEUE_PTR_W+1)'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_entry = slots[rd_ptr_reg];

    // pointer and fill bookkeeping
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge aclk) begin
        if (push) begin
            slots[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

// ===== sv/rgbm_back.sv =====
// rgbm_back: bit packing into the byte accumulator and the output register
// depends on rgbm_pkg for the entry type and refill value

module rgbm_back (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                q_not_empty,
    input  rgbm_pkg::q_entry_t  q_entry,
    output logic                q_pop,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [7:0]          packed_byte,
    output logic [rgbm_pkg::BYTE_COL_W-1:0] byte_column,
    output logic [rgbm_pkg::OUT_ROW_W-1:0]  out_row,
    output logic                row_end
);
    import rgbm_pkg::*;

    logic [7:0]            acc_reg, acc_next;
    logic [7:0]            acc_upd;
    logic [7:0]            bit_mask;
    logic                  valid_reg, valid_next;
    logic [7:0]            byte_reg;
    logic [BYTE_COL_W-1:0] col_reg;
    logic [OUT_ROW_W-1:0]  row_reg;
    logic                  end_reg;
    logic                  out_free;
    logic                  load;

    // take a queued pixel whenever the output slot is free or being drained
    assign out_free = !valid_reg || out_ready;
    assign q_pop    = q_not_empty && out_free;
    assign load     = q_pop && q_entry.emit;

    // set or clear the pixel's bit, msb is leftmost column
    assign bit_mask = BIT_MSB >> q_entry.bit_pos;
    assign acc_upd  = q_entry.white ? (acc_reg | bit_mask) : (acc_reg & ~bit_mask);

    always_comb begin
        acc_next   = acc_reg;
        valid_next = valid_reg;
        if (out_ready) begin
            valid_next = 1'b0;
        end
        if (q_pop) begin
            acc_next = q_entry.emit ? ACC_ALL_WHITE : acc_upd;
        end
        if (load) begin
            valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg   <= ACC_ALL_WHITE;
            valid_reg <= 1'b0;
        end else begin
            acc_reg   <= acc_next;
            valid_reg <= valid_next;
        end
    end

    // result payload
    always_ff @(posedge aclk) begin
        if (load) begin
            byte_reg <= acc_upd;
            col_reg  <= q_entry.byte_col;
            row_reg  <= q_entry.row;
            end_reg  <= q_entry.last_col;
        end
    end

    assign out_valid   = valid_reg;
    assign packed_byte = byte_reg;
    assign byte_column = col_reg;
    assign out_row     = row_reg;
    assign row_end     = end_reg;

endmodule

// ===== tb/sv/tb_rgb565_to_mono_packer_unit.sv =====
// tb_rgb565_to_mono_packer_unit: self-checking bench for the rgb565 mono packer
// depends on rgbm_pkg and rgb565_to_mono_packer_unit; scoreboard class lives here

module tb_rgb565_to_mono_packer_unit;
    import rgbm_pkg::*;

    localparam int COORD_W = 10;
    localparam int S_DATA_W = ((16 + 2 * COORD_W + 7) / 8) * 8;
    localparam int unsigned WHITE_LUMA_MIN = 128000;
    localparam int HOLD_CYCLES = 50;
    localparam int SETTLE_CYCLES = 10;
    localparam int DRAIN_LIMIT = 5000;
    localparam int CYCLE_LIMIT = 300000;

    // one expected or observed packed byte
    typedef struct packed {
        logic [7:0]         bits;
        logic [6:0]         byte_col;
        logic [9:0]         row;
        logic               row_end;
    } mono_byte_t;

    // scoreboard: window copy, packing byte and bytes still to arrive
    class mono_pack_scoreboard;
        bit [COORD_W-1:0] win_x_first;
        bit [COORD_W-1:0] win_x_last;
        bit [COORD_W-1:0] win_y_first;
        bit [COORD_W-1:0] win_y_last;
        bit [7:0]         pack_bits;
        mono_byte_t       pending[$];
        int               mismatches;
        int               compared;

        function new();
            win_x_first = 0;
            win_x_last  = 799;
            win_y_first = 0;
            win_y_last  = 479;
            pack_bits   = 8'hFF;
            mismatches  = 0;
            compared    = 0;
        endfunction

        function void set_window(reg_idx_t idx, bit [COORD_W-1:0] value);
            case (idx)
                REG_X_FIRST: win_x_first = value;
                REG_X_LAST:  win_x_last  = value;
                REG_Y_FIRST: win_y_first = value;
                REG_Y_LAST:  win_y_last  = value;
                default: ;
            endcase
        endfunction

        function bit [COORD_W-1:0] window_value(reg_idx_t idx);
            case (idx)
                REG_X_FIRST: return win_x_first;
                REG_X_LAST:  return win_x_last;
                REG_Y_FIRST: return win_y_first;
                default:     return win_y_last;
            endcase
        endfunction

        // 8-bit expansion of each channel, weighted sum against threshold
        function bit luma_is_white(bit [15:0] pix);
            int unsigned red8, green8, blue8, luma;
            red8   = int'(pix[15:11]) * 255 / 31;
            green8 = int'(pix[10:5]) * 255 / 63;
            blue8  = int'(pix[4:0]) * 255 / 31;
            luma   = red8 * 299 + green8 * 587 + blue8 * 114;
            return luma >= WHITE_LUMA_MIN;
        endfunction

        // accepted pixel: returns 1 when it lies inside the window
        function bit note_pixel(bit [15:0] pix, bit [COORD_W-1:0] col,
                                bit [COORD_W-1:0] row);
            mono_byte_t want;
            bit [7:0]   mask;
            bit         at_last;
            if (col < win_x_first || col > win_x_last ||
                row < win_y_first || row > win_y_last)
                return 1'b0;
            mask = 8'h80 >> col[2:0];
            if (luma_is_white(pix)) begin
                pack_bits |= mask;
            end else begin
                pack_bits &= ~mask;
            end
            at_last = (col == win_x_last);
            if (col[2:0] == 3'd7 || at_last) begin
                want.bits     = pack_bits;
                want.byte_col = col[9:3];
                want.row      = row;
                want.row_end  = at_last;
                pending.push_back(want);
                pack_bits = 8'hFF;
            end
            return 1'b1;
        endfunction

        function void report(string what, mono_byte_t want, mono_byte_t got);
            mismatches++;
            if (mismatches <= 10)
                $display({"mismatch (%s): expected byte %02h col %0d row %0d end %0b,",
                          " got byte %02h col %0d row %0d end %0b"},
                         what, want.bits, want.byte_col, want.row, want.row_end,
                         got.bits, got.byte_col, got.row, got.row_end);
        endfunction

        // accepted output transfer against the oldest expected byte
        function void check_byte(logic [31:0] data, logic last);
            mono_byte_t got, want;
            got.bits     = data[7:0];
            got.byte_col = data[14:8];
            got.row      = data[24:15];
            got.row_end  = last;
            compared++;
            if (pending.size() == 0) begin
                want = '0;
                report("no byte expected", want, got);
            end else begin
                want = pending.pop_front();
                if (got !== want)
                    report("field", want, got);
            end
        endfunction

        function void check_register(reg_idx_t idx, logic [31:0] got);
            logic [31:0] want;
            want = 32'(window_value(idx));
            if (got !== want) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch (register %s): expected %0d, got %0d",
                             idx.name(), want, got);
            end
        endfunction
    endclass

    logic                aclk;
    logic                aresetn;
    logic                s_tvalid;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata;
    logic                m_tvalid;
    logic                m_tready;
    logic [31:0]         m_tdata;
    logic                m_tlast;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [3:0]          paddr;
    logic [31:0]         pwdata;
    logic [31:0]         prdata;
    logic                pready;

    mono_pack_scoreboard sb;
    int  sent_count;
    int  kept_count;
    int  send_idle_pct;
    int  recv_idle_pct;
    bit  hold_req;
    int  holds_done;
    int  cycle_count;

    rgb565_to_mono_packer_unit #(.COORD_BITS(COORD_W)) u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // clock
    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    // output side: random ready bursts and the long hold
    initial begin
        m_tready = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                holds_done++;
                m_tready <= 1'b0;
                for (int n = 0; n < HOLD_CYCLES; n++) @(negedge aclk);
            end else if (recv_idle_pct != 0 && $urandom_range(1, 100) <= recv_idle_pct) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 3)) @(negedge aclk);
            end
            m_tready <= 1'b1;
            @(negedge aclk);
        end
    end

    // output transfers
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_byte(m_tdata, m_tlast);
    end

    // run limit
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("CHECKS FAILED");
        $finish;
    end

    // one pixel transfer, optionally after an idle burst
    task automatic send_pixel(input bit [15:0] pix, input bit [9:0] col, input bit [9:0] row);
        if (send_idle_pct != 0 && $urandom_range(1, 100) <= send_idle_pct) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= S_DATA_W'({row, col, pix});
        do @(posedge aclk); while (!s_tready);
        if (sb.note_pixel(pix, col, row))
            kept_count++;
        sent_count++;
        @(negedge aclk);
    endtask

    function automatic bit [15:0] random_pixel();
        int unsigned pick;
        pick = $urandom_range(0, 9);
        if (pick == 0) return 16'h0000;
        if (pick == 1) return 16'hFFFF;
        return 16'($urandom_range(0, 65535));
    endfunction

    // run of pixels along one row, stepping by step columns
    task automatic send_run(input int row, input int col0, input int len, input int step);
        int c;
        c = col0;
        for (int i = 0; i < len; i++) begin
            if (c < 0 || c > 1023)
                break;
            send_pixel(random_pixel(), c[9:0], row[9:0]);
            c += step;
        end
    endtask

    task automatic stop_input();
        s_tvalid <= 1'b0;
    endtask

    // waits on the clock before each check, even when nothing is pending
    task automatic wait_bytes_done();
        do @(negedge aclk); while (sb.pending.size() != 0);
    endtask

    // idle stream before a register write
    task automatic settle();
        stop_input();
        wait_bytes_done();
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    // apb write then read-back of one window register
    task automatic write_window(input reg_idx_t idx, input int unsigned value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        sb.set_window(idx, value[9:0]);
        @(negedge aclk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        sb.check_register(idx, prdata);
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_window(input int xf, input int xl, input int yf, input int yl);
        write_window(REG_X_FIRST, xf);
        write_window(REG_X_LAST, xl);
        write_window(REG_Y_FIRST, yf);
        write_window(REG_Y_LAST, yl);
    endtask

    // mostly raster runs inside the window, some broken runs and noise
    task automatic run_random(input int target_kept);
        int first_kept, first_sent, kind, row, start, len, xf, xl;
        first_kept = kept_count;
        first_sent = sent_count;
        while (kept_count - first_kept < target_kept &&
               sent_count - first_sent < 4 * target_kept) begin
            xf   = sb.win_x_first;
            xl   = sb.win_x_last;
            row  = $urandom_range(sb.win_y_last, sb.win_y_first);
            kind = $urandom_range(0, 99);
            if (kind < 45) begin
                start = $urandom_range(xl, xf);
                if ($urandom_range(0, 1))
                    start = start & ~7;
                send_run(row, start, $urandom_range(1, 24), 1);
            end else if (kind < 75) begin
                // run that ends on the window's last column
                len   = $urandom_range(1, 20);
                start = xl - len + 1;
                if (start < xf) start = xf;
                send_run(row, start, xl - start + 1, 1);
            end else if (kind < 85) begin
                // skipped or backward columns
                start = $urandom_range(xl, xf);
                send_run(row, start, $urandom_range(2, 10), $urandom_range(0, 1) ? 2 : -1);
            end else begin
                repeat ($urandom_range(1, 4))
                    send_pixel(random_pixel(), 10'($urandom_range(0, 1023)),
                               10'($urandom_range(0, 1023)));
            end
        end
    endtask

    // stimulus
    initial begin
        int drain_wait;
        sb = new();
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        hold_req = 1'b0;
        holds_done    = 0;
        sent_count    = 0;
        kept_count    = 0;
        send_idle_pct = 20;
        recv_idle_pct = 20;
        repeat (2) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // reset window: channel extremes, near-threshold grays, gaps, edges
        send_pixel(16'h0000, 0, 0);
        send_pixel(16'hFFFF, 1, 0);
        send_pixel(16'hF800, 2, 0);
        send_pixel(16'h07E0, 3, 0);
        send_pixel(16'h001F, 4, 0);
        send_pixel(16'h7BEF, 5, 0);
        send_pixel(16'h8410, 6, 0);
        send_pixel(16'hFFFF, 7, 0);
        send_pixel(16'h0000, 8, 1);
        send_pixel(16'h0000, 10, 1);
        send_pixel(16'hFFFF, 15, 1);
        send_pixel(16'h0000, 23, 2);
        send_pixel(16'h0000, 17, 2);
        send_pixel(16'h0000, 798, 479);
        send_pixel(16'hFFFF, 799, 479);
        send_pixel(16'hFFFF, 800, 0);
        send_pixel(16'hFFFF, 0, 480);
        send_pixel(16'hFFFF, 1023, 1023);
        send_pixel(16'h0000, 1023, 0);
        run_random(250);
        settle();

        // unaligned window; output held off while rows keep coming
        set_window(3, 20, 5, 9);
        hold_req = 1'b1;
        send_run(5, 0, 24, 1);
        send_run(6, 0, 24, 1);
        recv_idle_pct = 35;
        run_random(200);
        settle();

        // empty windows on either axis
        set_window(700, 5, 0, 1023);
        send_run(3, 0, 9, 1);
        send_pixel(16'h0000, 700, 3);
        send_pixel(16'hFFFF, 5, 3);
        settle();
        set_window(0, 1023, 9, 2);
        send_run(2, 0, 8, 1);
        send_run(9, 8, 8, 1);
        send_pixel(16'h0000, 0, 5);
        settle();

        // whole coordinate range, with a pause until every byte is out
        set_window(0, 1023, 0, 1023);
        send_idle_pct = 30;
        recv_idle_pct = 10;
        send_pixel(16'hFFFF, 1023, 1023);
        send_pixel(16'h0000, 0, 0);
        run_random(150);
        stop_input();
        wait_bytes_done();
        run_random(150);
        settle();

        // single-pixel window at the far corner
        set_window(1023, 1023, 1023, 1023);
        send_pixel(16'h0000, 1023, 1023);
        send_pixel(16'hFFFF, 1022, 1023);
        send_pixel(16'hFFFF, 1023, 1022);
        send_pixel(16'hFFFF, 1023, 1023);
        settle();

        // closing stretch at full rate on both sides
        send_idle_pct = 0;
        recv_idle_pct = 0;
        set_window(100, 611, 0, 1023);
        run_random(600);
        stop_input();

        // drain
        drain_wait = 0;
        while (sb.pending.size() != 0 && drain_wait < DRAIN_LIMIT) begin
            @(negedge aclk);
            drain_wait++;
        end
        repeat (SETTLE_CYCLES) @(negedge aclk);
        if (sb.pending.size() != 0)
            $display("%0d expected bytes never arrived", sb.pending.size());
        $display("sent %0d pixels (%0d inside the window) over seven window settings",
                 sent_count, kept_count);
        $display("compared %0d bytes, %0d long output holds, %0d mismatches",
                 sb.compared, holds_done, sb.mismatches);
        if (sb.mismatches == 0 && sb.pending.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
sv/rgbm_pkg.sv
sv/rgbm_front.sv
sv/rgbm_queue.sv
sv/rgbm_back.sv
sv/rgb565_to_mono_packer_unit.sv
tb/sv/tb_rgb565_to_mono_packer_unit.sv
